// ===== sv/lirs_pkg.sv =====
// Package for the linear interpolation resampler: fixed-point constants,
// request types, controller states and the controller/datapath interface.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lirs_pkg;

  localparam int unsigned FRACTION_BITS = 12;
  localparam int unsigned PHASE_W       = 17;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned FRAC8_W       = 8;
  localparam int unsigned MAX_RESULTS   = 64;
  localparam int unsigned RUN_CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [PHASE_W-1:0]   PHASE_ONE = PHASE_W'(1) << FRACTION_BITS;
  localparam logic [RUN_CNT_W-1:0] RUN_MAX   = RUN_CNT_W'(MAX_RESULTS);
  localparam logic [RUN_CNT_W-1:0] RUN_LAST  = RUN_CNT_W'(MAX_RESULTS - 1);

  // Register indexes (paddr[2]).
  localparam logic REG_PHASE_STEP   = 1'b0;
  localparam logic REG_OUTPUT_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] PHASE_STEP_RST   = 16'd4096;
  localparam logic [CFG_W-1:0] OUTPUT_LIMIT_RST = 16'd256;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_buffer;
    logic                       last_of_run;
  } out_req_t;

  typedef struct packed {
    logic [CFG_W-1:0] phase_step;
    logic [CFG_W-1:0] output_limit;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic prime;   // restart: take sample as previous, clear phase and count
    logic load;    // take sample as the current one, clear run count
    logic emit;    // produce one output into the output register
    logic finish;  // close the interval: wrap phase, advance the sample
  } dp_cmd_t;

  typedef struct packed {
    logic primed;
    logic can_emit;   // phase inside interval, limit and run cap not reached
    logic emit_last;  // an output made now ends the run
    logic slot_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== sv/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation resampler: register file, controller
// and datapath. Depends on lirs_pkg, lirs_cfg, lirs_ctrl and lirs_dp.
`timescale 1ns / 1ps

// Streaming linear-interpolation resampler for signed 16-bit samples. A phase
// accumulator with 12 fraction bits advances by phase_step per output, and
// each output is a + (((b - a) * f) >>> 8), where a and b are the previous
// and the current input sample and f is the top 8 fraction bits. A request
// with restart set (or the first request after reset) only primes the
// previous sample and clears the phase and the output count; it produces
// nothing. Any other request is loaded and then yields its outputs; the
// block stalls further requests until it has finished the item. The single
// shared interpolator makes one output per cycle whenever the output side
// does not stall, and an output stall holds up the current item until the
// output register is free again. At most 64 outputs
// follow one input, output stops after output_limit outputs per buffer,
// last_of_buffer marks the output that reaches the limit and last_of_run
// marks the final output of an input. A finished output waits in an output
// register, so the block takes the next request while it is still held.
// Registers: phase_step at byte address 0, output_limit at byte address 4.

module linear_interp_resampler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lirs_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lirs_pkg::out_req_t              out_req_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lirs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lirs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lirs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lirs_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lirs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lirs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_req_i.restart),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  lirs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== sv/lirs_cfg.sv =====
// APB-style register file of the resampler: phase step and output limit.
// Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lirs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lirs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lirs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output lirs_pkg::cfg_t                 cfg_o
);
  import lirs_pkg::*;

  logic [CFG_W-1:0] phase_step_q, phase_step_d;
  logic [CFG_W-1:0] output_limit_q, output_limit_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    phase_step_d   = phase_step_q;
    output_limit_d = output_limit_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_PHASE_STEP:   phase_step_d   = pwdata[CFG_W-1:0];
        REG_OUTPUT_LIMIT: output_limit_d = pwdata[CFG_W-1:0];
        default:          phase_step_d   = phase_step_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PHASE_STEP:   prdata = APB_DATA_W'(phase_step_q);
      REG_OUTPUT_LIMIT: prdata = APB_DATA_W'(output_limit_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= PHASE_STEP_RST;
      output_limit_q <= OUTPUT_LIMIT_RST;
    end else begin
      phase_step_q   <= phase_step_d;
      output_limit_q <= output_limit_d;
    end
  end

  assign cfg_o.phase_step   = phase_step_q;
  assign cfg_o.output_limit = output_limit_q;

endmodule

// ===== sv/lirs_ctrl.sv =====
// Controller state machine of the resampler: accepts requests and sequences
// the datapath through one interval per input. Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_restart_i,
  output logic                 in_stall_o,
  input  lirs_pkg::dp_status_t status_i,
  output lirs_pkg::dp_cmd_t    cmd_o
);
  import lirs_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_restart_i || !status_i.primed) begin
            cmd_o.prime = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!status_i.can_emit) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/lirs_dp.sv =====
// Datapath of the resampler: sample, phase and count registers, the shared
// interpolator and the output register. Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lirs_pkg::cfg_t       cfg_i,
  input  lirs_pkg::in_req_t    in_req_i,
  input  lirs_pkg::dp_cmd_t    cmd_i,
  output lirs_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lirs_pkg::out_req_t   out_req_o
);
  import lirs_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [SAMPLE_W-1:0] cur_q, cur_d;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [CFG_W-1:0]           count_q, count_d;
  logic [RUN_CNT_W-1:0]       run_q, run_d;
  logic                       primed_q, primed_d;
  logic                       out_valid_q, out_valid_d;
  out_req_t                   out_q, out_d;

  logic [PHASE_W-1:0]         phase_adv, phase_src;
  logic [CFG_W-1:0]           count_inc;
  logic [FRAC8_W-1:0]         frac8;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W+FRAC8_W+1:0] prod;
  logic signed [SAMPLE_W-1:0] interp;
  logic                       hit_limit;

  assign phase_adv = phase_q + PHASE_W'(cfg_i.phase_step);
  assign count_inc = count_q + CFG_W'(1);
  assign hit_limit = (count_inc == cfg_i.output_limit);
  assign frac8     = phase_q[FRACTION_BITS-1 -: FRAC8_W];

  // The arithmetic shift by 8 floors the scaled difference.
  assign diff   = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};
  assign prod   = diff * $signed({1'b0, frac8});
  assign interp = prev_q + prod[SAMPLE_W+FRAC8_W-1:FRAC8_W];

  assign status_o.primed    = primed_q;
  assign status_o.can_emit  = (phase_q < PHASE_ONE) && (count_q < cfg_i.output_limit)
                              && (run_q != RUN_MAX);
  assign status_o.emit_last = (phase_adv >= PHASE_ONE) || hit_limit || (run_q == RUN_LAST);
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  assign phase_src = cmd_i.emit ? phase_adv : phase_q;

  always_comb begin
    prev_d      = prev_q;
    cur_d       = cur_q;
    phase_d     = phase_q;
    count_d     = count_q;
    run_d       = run_q;
    primed_d    = primed_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.prime) begin
      prev_d   = in_req_i.sample_in;
      phase_d  = '0;
      count_d  = '0;
      primed_d = 1'b1;
    end
    if (cmd_i.load) begin
      cur_d = in_req_i.sample_in;
      run_d = '0;
    end
    if (cmd_i.emit) begin
      count_d            = count_inc;
      run_d              = run_q + RUN_CNT_W'(1);
      phase_d            = phase_adv;
      out_d.sample_out     = interp;
      out_d.last_of_buffer = hit_limit;
      out_d.last_of_run    = status_o.emit_last;
      out_valid_d        = 1'b1;
    end
    // An interval left while still inside it restarts the phase at the new sample.
    if (cmd_i.finish) begin
      phase_d = (phase_src >= PHASE_ONE) ? (phase_src - PHASE_ONE) : '0;
      prev_d  = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    phase_q <= phase_d;
    count_q <= count_d;
    run_q   <= run_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== test/tb_linear_interp_resampler_top.sv =====
// Self-checking testbench for the linear interpolation resampler top level.
// Holds a cycle-free predictor of the resampler and a result checker.
// Depends on lirs_pkg and linear_interp_resampler_top.
`timescale 1ns / 1ps

module tb_linear_interp_resampler_top;
  import lirs_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 16;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 40;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_req_t               in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_req_t              out_req_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state, mirrored from the block's registers.
  logic [CFG_W-1:0]           cfg_step     = PHASE_STEP_RST;
  logic [CFG_W-1:0]           cfg_limit    = OUTPUT_LIMIT_RST;
  logic signed [SAMPLE_W-1:0] held_sample  = '0;
  logic [PHASE_W-1:0]         read_phase   = '0;
  logic [CFG_W-1:0]           emit_total   = '0;
  logic                       is_primed    = 1'b0;

  out_req_t exp_outputs[$];
  int       err_count  = 0;
  int       idle_count = 0;

  // Pacing of both sides.
  int stall_pct  = 0;
  int stall_left = 0;
  bit stall_on   = 1'b0;
  int burst_left = 0;
  int gap_max    = 0;
  logic signed [SAMPLE_W-1:0] walk_sample = '0;

  linear_interp_resampler_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, wanted %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic in_req_t make_req(input logic signed [SAMPLE_W-1:0] smp, input logic rs);
    in_req_t r;
    r.sample_in = smp;
    r.restart   = rs;
    return r;
  endfunction

  // Works out every output that one accepted request causes and queues it.
  task automatic predict_outputs(input in_req_t req);
    out_req_t            run_buf [MAX_RESULTS];
    int                  n;
    int                  diff;
    int                  prod;
    int                  y;
    logic [FRAC8_W-1:0]  frac;
    n = 0;
    if (req.restart || !is_primed) begin
      // A restart, or the first request ever, only primes the sample.
      held_sample  = req.sample_in;
      read_phase   = '0;
      emit_total   = '0;
      is_primed    = 1'b1;
    end else begin
      while (read_phase < PHASE_ONE && emit_total < cfg_limit && n < MAX_RESULTS) begin
        frac = read_phase[FRACTION_BITS-1 -: FRAC8_W];
        diff = int'(req.sample_in) - int'(held_sample);
        prod = diff * int'(frac);
        y    = int'(held_sample) + (prod >>> 8);
        emit_total = emit_total + 1'b1;
        run_buf[n].sample_out     = y[SAMPLE_W-1:0];
        run_buf[n].last_of_buffer = (emit_total == cfg_limit);
        run_buf[n].last_of_run    = 1'b0;
        read_phase = read_phase + PHASE_W'(cfg_step);
        n++;
      end
      if (n > 0) run_buf[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) exp_outputs.push_back(run_buf[i]);
      // Either step over the sample just passed, or restart at the new one when
      // the run cap or the buffer limit cut the interval short.
      if (read_phase >= PHASE_ONE) read_phase = read_phase - PHASE_ONE;
      else read_phase = '0;
      held_sample = req.sample_in;
    end
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic send_sample(input in_req_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_outputs(req);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Sends in bursts of random length separated by random gaps.
  task automatic send_paced(input in_req_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) idle_sender($urandom_range(0, gap_max));
    end
    burst_left--;
    send_sample(req);
  endtask

  // Waits until every queued output has come out and the block has settled.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (exp_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [CFG_W-1:0] value);
    drain_block();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_PHASE_STEP) cfg_step = value;
    else cfg_limit = value;
  endtask

  // Receiver: alternating stall and ready stretches of random length.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 99) < stall_pct);
      stall_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 12);
    end
    stall_left--;
    out_stall_i <= stall_on;
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_outputs
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_outputs.size() == 0) begin
        report_mismatch("output with nothing pending", int'(out_req_o.sample_out), 0);
      end else begin
        want = exp_outputs.pop_front();
        if (out_req_o.sample_out !== want.sample_out)
          report_mismatch("sample_out", int'(out_req_o.sample_out), int'(want.sample_out));
        if (out_req_o.last_of_buffer !== want.last_of_buffer)
          report_mismatch("last_of_buffer", int'(out_req_o.last_of_buffer),
                          int'(want.last_of_buffer));
        if (out_req_o.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", int'(out_req_o.last_of_run), int'(want.last_of_run));
      end
    end
  end

  // Ends a hung run: counts cycles in which no request moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Reset settings: the very first request is unprimed and acts as a restart.
  task automatic test_power_on_defaults();
    stall_pct = 30;
    send_sample(make_req(16'sd32767, 1'b0));
    send_sample(make_req(-16'sd32768, 1'b0));
    send_sample(make_req(16'sd32767, 1'b0));
    send_sample(make_req(16'sd0, 1'b1));
    send_sample(make_req(-16'sd1, 1'b0));
  endtask

  // Half step with full-scale swings between the extremes.
  task automatic test_full_scale_upsample();
    write_reg(REG_PHASE_STEP, 16'd2048);
    write_reg(REG_OUTPUT_LIMIT, 16'd65535);
    send_sample(make_req(-16'sd32768, 1'b1));
    send_sample(make_req(16'sd32767, 1'b0));
    send_sample(make_req(-16'sd32768, 1'b0));
    send_sample(make_req(16'sd32767, 1'b0));
  endtask

  // A limit of one, requests after the limit, a restart, then a zero limit.
  task automatic test_output_limit();
    write_reg(REG_OUTPUT_LIMIT, 16'd1);
    send_sample(make_req(16'sd100, 1'b1));
    send_sample(make_req(16'sd200, 1'b0));
    send_sample(make_req(16'sd300, 1'b0));
    send_sample(make_req(16'sd5, 1'b1));
    send_sample(make_req(16'sd7, 1'b0));
    write_reg(REG_OUTPUT_LIMIT, 16'd0);
    send_sample(make_req(16'sd1, 1'b1));
    send_sample(make_req(16'sd2, 1'b0));
  endtask

  // Steps so small that the run cap ends an item, with and without phase left.
  task automatic test_tiny_step();
    write_reg(REG_OUTPUT_LIMIT, 16'd65535);
    write_reg(REG_PHASE_STEP, 16'd32);
    send_sample(make_req(16'sd0, 1'b1));
    send_sample(make_req(16'sd32767, 1'b0));
    send_sample(make_req(-16'sd32768, 1'b0));
    write_reg(REG_PHASE_STEP, 16'd0);
    send_sample(make_req(16'sd10, 1'b0));
    write_reg(REG_PHASE_STEP, 16'd64);
    send_sample(make_req(-16'sd1, 1'b0));
  endtask

  // Largest step: after one output the phase lies beyond several samples.
  task automatic test_large_step();
    write_reg(REG_PHASE_STEP, 16'd65535);
    send_sample(make_req(16'sd1, 1'b1));
    send_sample(make_req(16'sd2, 1'b0));
    send_sample(make_req(16'sd3, 1'b0));
    send_sample(make_req(16'sd4, 1'b0));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int walk;
    case ($urandom_range(0, 19))
      0: walk = 32767;
      1: walk = -32768;
      2, 3, 4, 5, 6, 7: begin
        walk = int'(walk_sample) + int'($urandom_range(0, 4000)) - 2000;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
      end
      default: walk = int'($signed(16'($urandom)));
    endcase
    walk_sample = walk[SAMPLE_W-1:0];
    return walk_sample;
  endfunction

  // Buffers of random audio under a new setting each phase. Most buffers open
  // with a restart; a few continue the old buffer or restart in the middle.
  task automatic test_random_buffers();
    logic [CFG_W-1:0] step_val;
    logic [CFG_W-1:0] limit_val;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        step_val  = 16'd65535;
        limit_val = 16'd65535;
      end else if (p == RAND_PHASES - 1) begin
        step_val  = 16'd64;
        limit_val = 16'd65535;
      end else begin
        case ($urandom_range(0, 6))
          0: step_val = 16'd2048;
          1: step_val = 16'd4096;
          2: step_val = 16'($urandom_range(64, 65535));
          3: step_val = 16'($urandom_range(1024, 8192));
          4: step_val = 16'($urandom_range(300, 1500));
          5: step_val = 16'($urandom_range(8192, 20000));
          default: step_val = 16'($urandom_range(1, 63));
        endcase
        case ($urandom_range(0, 3))
          0: limit_val = 16'($urandom_range(1, 16));
          1: limit_val = 16'($urandom_range(17, 120));
          2: limit_val = 16'd65535;
          default: limit_val = 16'($urandom_range(1, 65535));
        endcase
      end
      write_reg(REG_PHASE_STEP, step_val);
      write_reg(REG_OUTPUT_LIMIT, limit_val);
      case (p % 3)
        0: stall_pct = 0;
        1: stall_pct = 35;
        default: stall_pct = 70;
      endcase
      gap_max = (p % 2 == 0) ? 6 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 0) send_paced(make_req(next_sample(), ($urandom_range(0, 3) != 0)));
        else send_paced(make_req(next_sample(), ($urandom_range(0, 24) == 0)));
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_power_on_defaults();
    test_full_scale_upsample();
    test_output_limit();
    test_tiny_step();
    test_large_step();
    test_random_buffers();
    drain_block();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lirs_pkg.sv
sv/lirs_cfg.sv
sv/lirs_ctrl.sv
sv/lirs_dp.sv
sv/linear_interp_resampler_top.sv
test/tb_linear_interp_resampler_top.sv
